/* src/rvd_pkg.sv */
// Shared types, opcode values and lookup functions for the RV32I decoder.
// Depends on nothing; the stage modules, top level and testbench refer to it by scoped names.
`default_nettype none

package rvd_pkg;

    // Major opcodes, bits 6..0 of the instruction
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;

    localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

    // funct7 values that matter
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Immediate format codes
    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_I    = 3'd1;
    localparam logic [2:0] FMT_S    = 3'd2;
    localparam logic [2:0] FMT_B    = 3'd3;
    localparam logic [2:0] FMT_U    = 3'd4;
    localparam logic [2:0] FMT_J    = 3'd5;

    // Dense operation codes
    localparam logic [5:0] OP_ILLEGAL = 6'd0;
    localparam logic [5:0] OP_ADD     = 6'd1;
    localparam logic [5:0] OP_SUB     = 6'd2;
    localparam logic [5:0] OP_SLL     = 6'd3;
    localparam logic [5:0] OP_SLT     = 6'd4;
    localparam logic [5:0] OP_SLTU    = 6'd5;
    localparam logic [5:0] OP_XOR     = 6'd6;
    localparam logic [5:0] OP_SRL     = 6'd7;
    localparam logic [5:0] OP_SRA     = 6'd8;
    localparam logic [5:0] OP_OR      = 6'd9;
    localparam logic [5:0] OP_AND     = 6'd10;
    localparam logic [5:0] OP_ADDI    = 6'd11;
    localparam logic [5:0] OP_SLTI    = 6'd12;
    localparam logic [5:0] OP_SLTIU   = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_ORI     = 6'd15;
    localparam logic [5:0] OP_ANDI    = 6'd16;
    localparam logic [5:0] OP_SLLI    = 6'd17;
    localparam logic [5:0] OP_SRLI    = 6'd18;
    localparam logic [5:0] OP_SRAI    = 6'd19;
    localparam logic [5:0] OP_LB      = 6'd20;
    localparam logic [5:0] OP_LH      = 6'd21;
    localparam logic [5:0] OP_LW      = 6'd22;
    localparam logic [5:0] OP_LBU     = 6'd23;
    localparam logic [5:0] OP_LHU     = 6'd24;
    localparam logic [5:0] OP_SB      = 6'd25;
    localparam logic [5:0] OP_SH      = 6'd26;
    localparam logic [5:0] OP_SW      = 6'd27;
    localparam logic [5:0] OP_BEQ     = 6'd28;
    localparam logic [5:0] OP_BNE     = 6'd29;
    localparam logic [5:0] OP_BLT     = 6'd30;
    localparam logic [5:0] OP_BGE     = 6'd31;
    localparam logic [5:0] OP_BLTU    = 6'd32;
    localparam logic [5:0] OP_BGEU    = 6'd33;
    localparam logic [5:0] OP_JAL     = 6'd34;
    localparam logic [5:0] OP_JALR    = 6'd35;
    localparam logic [5:0] OP_LUI     = 6'd36;
    localparam logic [5:0] OP_AUIPC   = 6'd37;
    localparam logic [5:0] OP_ECALL   = 6'd38;
    localparam logic [5:0] OP_EBREAK  = 6'd39;
    localparam logic [5:0] OP_FENCE   = 6'd40;
    localparam logic [5:0] OP_FENCE_I = 6'd41;

    // Instruction class found in the first stage
    typedef enum logic [3:0] {
        CLS_ILLEGAL,
        CLS_OP,
        CLS_OPIMM,
        CLS_LOAD,
        CLS_STORE,
        CLS_BRANCH,
        CLS_JAL,
        CLS_JALR,
        CLS_LUI,
        CLS_AUIPC,
        CLS_SYSTEM,
        CLS_FENCE
    } cls_t;

    // First stage to second stage
    typedef struct packed {
        cls_t        cls;
        logic [31:0] word;
    } s1_t;

    // Second stage to third stage
    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [2:0]  fmt;
        logic [31:0] word;
    } s2_t;

    // funct3 tables; R-type entries assume funct7 is zero
    function automatic logic [5:0] r_op(input logic [2:0] f3);
        logic [5:0] op;
        unique case (f3)
            3'd0:    op = OP_ADD;
            3'd1:    op = OP_SLL;
            3'd2:    op = OP_SLT;
            3'd3:    op = OP_SLTU;
            3'd4:    op = OP_XOR;
            3'd5:    op = OP_SRL;
            3'd6:    op = OP_OR;
            default: op = OP_AND;
        endcase
        return op;
    endfunction

    function automatic logic [5:0] opimm_op(input logic [2:0] f3);
        logic [5:0] op;
        unique case (f3)
            3'd0:    op = OP_ADDI;
            3'd1:    op = OP_SLLI;
            3'd2:    op = OP_SLTI;
            3'd3:    op = OP_SLTIU;
            3'd4:    op = OP_XORI;
            3'd5:    op = OP_SRLI;
            3'd6:    op = OP_ORI;
            default: op = OP_ANDI;
        endcase
        return op;
    endfunction

    function automatic logic [5:0] load_op(input logic [2:0] f3);
        logic [5:0] op;
        unique case (f3)
            3'd0:    op = OP_LB;
            3'd1:    op = OP_LH;
            3'd2:    op = OP_LW;
            3'd4:    op = OP_LBU;
            3'd5:    op = OP_LHU;
            default: op = OP_ILLEGAL;
        endcase
        return op;
    endfunction

    function automatic logic [5:0] store_op(input logic [2:0] f3);
        logic [5:0] op;
        unique case (f3)
            3'd0:    op = OP_SB;
            3'd1:    op = OP_SH;
            3'd2:    op = OP_SW;
            default: op = OP_ILLEGAL;
        endcase
        return op;
    endfunction

    function automatic logic [5:0] branch_op(input logic [2:0] f3);
        logic [5:0] op;
        unique case (f3)
            3'd0:    op = OP_BEQ;
            3'd1:    op = OP_BNE;
            3'd4:    op = OP_BLT;
            3'd5:    op = OP_BGE;
            3'd6:    op = OP_BLTU;
            3'd7:    op = OP_BGEU;
            default: op = OP_ILLEGAL;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

/* src/rvd_if.sv */
// Valid/ready channel interfaces for instruction requests and decoded results.
// No dependencies.
`default_nettype none

interface rvd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvd_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  op_code;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic signed [31:0] immediate;
    logic [2:0]  imm_format;
    logic [31:0] raw_word;

    modport source (output valid, output op_code, output dest_reg, output src_reg_a,
                    output src_reg_b, output immediate, output imm_format,
                    output raw_word, input ready);
    modport sink   (input valid, input op_code, input dest_reg, input src_reg_a,
                    input src_reg_b, input immediate, input imm_format,
                    input raw_word, output ready);
endinterface

`default_nettype wire

/* src/rvd_class_stage.sv */
// Stage 1: registers the instruction word and classifies its major opcode.
// Depends on rvd_pkg.
`default_nettype none

module rvd_class_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_in,
    output      logic          ready_in,
    input  wire logic [31:0]   word_in,
    output      logic          valid_out,
    input  wire logic          ready_out,
    output      rvd_pkg::s1_t  data_out
);

    logic          valid_reg;
    rvd_pkg::s1_t  data_reg;
    rvd_pkg::s1_t  data_next;

    // Stage takes a request when empty or when its content moves on
    assign ready_in  = !valid_reg || ready_out;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    // Opcode classification
    always_comb
    begin
        data_next.word = word_in;
        unique case (word_in[6:0])
            rvd_pkg::OPC_OP:     data_next.cls = rvd_pkg::CLS_OP;
            rvd_pkg::OPC_OPIMM:  data_next.cls = rvd_pkg::CLS_OPIMM;
            rvd_pkg::OPC_LOAD:   data_next.cls = rvd_pkg::CLS_LOAD;
            rvd_pkg::OPC_STORE:  data_next.cls = rvd_pkg::CLS_STORE;
            rvd_pkg::OPC_BRANCH: data_next.cls = rvd_pkg::CLS_BRANCH;
            rvd_pkg::OPC_JAL:    data_next.cls = rvd_pkg::CLS_JAL;
            rvd_pkg::OPC_JALR:   data_next.cls = rvd_pkg::CLS_JALR;
            rvd_pkg::OPC_LUI:    data_next.cls = rvd_pkg::CLS_LUI;
            rvd_pkg::OPC_AUIPC:  data_next.cls = rvd_pkg::CLS_AUIPC;
            rvd_pkg::OPC_SYSTEM: data_next.cls = rvd_pkg::CLS_SYSTEM;
            rvd_pkg::OPC_FENCE:  data_next.cls = rvd_pkg::CLS_FENCE;
            default:             data_next.cls = rvd_pkg::CLS_ILLEGAL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* src/rvd_op_stage.sv */
// Stage 2: works out the operation code, operand fields and immediate.
// Depends on rvd_pkg.
`default_nettype none

module rvd_op_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_in,
    output      logic          ready_in,
    input  wire rvd_pkg::s1_t  data_in,
    output      logic          valid_out,
    input  wire logic          ready_out,
    output      rvd_pkg::s2_t  data_out
);

    logic          valid_reg;
    rvd_pkg::s2_t  data_reg;
    rvd_pkg::s2_t  data_next;

    logic [31:0] w;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;

    assign ready_in  = !valid_reg || ready_out;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    // Field extraction and immediate forms
    assign w     = data_in.word;
    assign f3    = w[14:12];
    assign f7    = w[31:25];
    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_u = w & rvd_pkg::UPPER_MASK;
    assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

    // Per-class decode; illegal results are cleared in the next stage
    always_comb
    begin
        data_next.word = w;
        data_next.op   = rvd_pkg::OP_ILLEGAL;
        data_next.rd   = 5'd0;
        data_next.rs1  = 5'd0;
        data_next.rs2  = 5'd0;
        data_next.imm  = 32'd0;
        data_next.fmt  = rvd_pkg::FMT_NONE;
        unique case (data_in.cls)
            rvd_pkg::CLS_OP:
            begin
                if (f7 == rvd_pkg::F7_BASE)
                    data_next.op = rvd_pkg::r_op(f3);
                else if (f7 == rvd_pkg::F7_ALT && f3 == 3'd0)
                    data_next.op = rvd_pkg::OP_SUB;
                else if (f7 == rvd_pkg::F7_ALT && f3 == 3'd5)
                    data_next.op = rvd_pkg::OP_SRA;
                data_next.rd  = w[11:7];
                data_next.rs1 = w[19:15];
                data_next.rs2 = w[24:20];
            end
            rvd_pkg::CLS_OPIMM:
            begin
                data_next.op  = rvd_pkg::opimm_op(f3);
                data_next.rd  = w[11:7];
                data_next.rs1 = w[19:15];
                data_next.imm = imm_i;
                data_next.fmt = rvd_pkg::FMT_I;
                // shifts: immediate is the shift amount, funct7 qualifies
                if (f3 == 3'd1 || f3 == 3'd5)
                begin
                    data_next.imm = {27'd0, w[24:20]};
                    if (f3 == 3'd5 && f7 == rvd_pkg::F7_ALT)
                        data_next.op = rvd_pkg::OP_SRAI;
                    else if (f7 != rvd_pkg::F7_BASE)
                        data_next.op = rvd_pkg::OP_ILLEGAL;
                end
            end
            rvd_pkg::CLS_LOAD:
            begin
                data_next.op  = rvd_pkg::load_op(f3);
                data_next.rd  = w[11:7];
                data_next.rs1 = w[19:15];
                data_next.imm = imm_i;
                data_next.fmt = rvd_pkg::FMT_I;
            end
            rvd_pkg::CLS_STORE:
            begin
                data_next.op  = rvd_pkg::store_op(f3);
                data_next.rs1 = w[19:15];
                data_next.rs2 = w[24:20];
                data_next.imm = imm_s;
                data_next.fmt = rvd_pkg::FMT_S;
            end
            rvd_pkg::CLS_BRANCH:
            begin
                data_next.op  = rvd_pkg::branch_op(f3);
                data_next.rs1 = w[19:15];
                data_next.rs2 = w[24:20];
                data_next.imm = imm_b;
                data_next.fmt = rvd_pkg::FMT_B;
            end
            rvd_pkg::CLS_JAL:
            begin
                data_next.op  = rvd_pkg::OP_JAL;
                data_next.rd  = w[11:7];
                data_next.imm = imm_j;
                data_next.fmt = rvd_pkg::FMT_J;
            end
            rvd_pkg::CLS_JALR:
            begin
                if (f3 == 3'd0)
                    data_next.op = rvd_pkg::OP_JALR;
                data_next.rd  = w[11:7];
                data_next.rs1 = w[19:15];
                data_next.imm = imm_i;
                data_next.fmt = rvd_pkg::FMT_I;
            end
            rvd_pkg::CLS_LUI:
            begin
                data_next.op  = rvd_pkg::OP_LUI;
                data_next.rd  = w[11:7];
                data_next.imm = imm_u;
                data_next.fmt = rvd_pkg::FMT_U;
            end
            rvd_pkg::CLS_AUIPC:
            begin
                data_next.op  = rvd_pkg::OP_AUIPC;
                data_next.rd  = w[11:7];
                data_next.imm = imm_u;
                data_next.fmt = rvd_pkg::FMT_U;
            end
            rvd_pkg::CLS_SYSTEM:
            begin
                // rd and rs1 bits are not checked
                if (f3 == 3'd0 && w[31:20] == 12'd0)
                    data_next.op = rvd_pkg::OP_ECALL;
                else if (f3 == 3'd0 && w[31:20] == 12'd1)
                    data_next.op = rvd_pkg::OP_EBREAK;
            end
            rvd_pkg::CLS_FENCE:
            begin
                if (f3 == 3'd0)
                    data_next.op = rvd_pkg::OP_FENCE;
                else if (f3 == 3'd1)
                    data_next.op = rvd_pkg::OP_FENCE_I;
            end
            default:
            begin
                data_next.op = rvd_pkg::OP_ILLEGAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* src/rvd_out_stage.sv */
// Stage 3: clears all but the op code and raw word of an illegal encoding and holds the result.
// Depends on rvd_pkg.
`default_nettype none

module rvd_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_in,
    output      logic          ready_in,
    input  wire rvd_pkg::s2_t  data_in,
    output      logic          valid_out,
    input  wire logic          ready_out,
    output      rvd_pkg::s2_t  data_out
);

    logic          valid_reg;
    rvd_pkg::s2_t  data_reg;
    rvd_pkg::s2_t  data_next;
    logic          illegal;

    assign ready_in  = !valid_reg || ready_out;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    // Illegal: only op code and raw word survive
    assign illegal = (data_in.op == rvd_pkg::OP_ILLEGAL);

    always_comb
    begin
        data_next = data_in;
        if (illegal)
        begin
            data_next.rd  = 5'd0;
            data_next.rs1 = 5'd0;
            data_next.rs2 = 5'd0;
            data_next.imm = 32'd0;
            data_next.fmt = rvd_pkg::FMT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* src/rv32i_instruction_decoder.sv */
// RV32I instruction decoder, top level: three-stage valid/ready pipeline.
// Depends on rvd_pkg, rvd_if, rvd_class_stage, rvd_op_stage, rvd_out_stage.
//
//   channel   direction  payload
//   instr     in         instruction_word (32)
//   decoded   out        op_code, dest_reg, src_reg_a, src_reg_b, immediate,
//                        imm_format, raw_word
//
// One request per cycle sustained while decoded is ready; each result passes through
// the class, decode and clear/output register stages after its request is taken.
// Reset clears the stage valid bits only; the pipeline is empty after reset.
// A stage takes new data when empty or when its content moves on, so a stall
// on decoded backs up stage by stage without loss or repetition.
`default_nettype none

module rv32i_instruction_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rvd_in_if.sink     instr,
    rvd_out_if.source  decoded
);

    logic          s1_valid;
    logic          s1_ready;
    rvd_pkg::s1_t  s1_data;
    logic          s2_valid;
    logic          s2_ready;
    rvd_pkg::s2_t  s2_data;
    rvd_pkg::s2_t  res;

    rvd_class_stage u_class (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (instr.valid),
        .ready_in  (instr.ready),
        .word_in   (instr.instruction_word),
        .valid_out (s1_valid),
        .ready_out (s1_ready),
        .data_out  (s1_data)
    );

    rvd_op_stage u_op (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .ready_in  (s1_ready),
        .data_in   (s1_data),
        .valid_out (s2_valid),
        .ready_out (s2_ready),
        .data_out  (s2_data)
    );

    rvd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .ready_in  (s2_ready),
        .data_in   (s2_data),
        .valid_out (decoded.valid),
        .ready_out (decoded.ready),
        .data_out  (res)
    );

    // Result fields onto the output channel
    assign decoded.op_code    = res.op;
    assign decoded.dest_reg   = res.rd;
    assign decoded.src_reg_a  = res.rs1;
    assign decoded.src_reg_b  = res.rs2;
    assign decoded.immediate  = $signed(res.imm);
    assign decoded.imm_format = res.fmt;
    assign decoded.raw_word   = res.word;

endmodule

`default_nettype wire

/* tb/sv/rv32i_instruction_decoder_tb.sv */
// Self-checking testbench for the RV32I instruction decoder pipeline.
// Uses rvd_pkg for opcode and format codes, and rvd_if for the channel interfaces.
// Expected decodes come from a predictor in this file and are checked in order.

module rv32i_instruction_decoder_tb;

    localparam int STALL_LIMIT = 3000;   // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 80;     // long output back-pressure stretch
    localparam int DRAIN_WAIT  = 8;      // pipeline depth plus margin
    localparam int PHASE_ITEMS = 180;
    localparam int SEND_IDLE [4] = '{0, 51, 0, 8};
    localparam int RECV_IDLE [4] = '{0, 0, 51, 8};

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [2:0]  fmt;
        logic [31:0] word;
    } decode_t;

    logic clk = 1'b0;
    logic rst_n;

    rvd_in_if  instr_ch ();
    rvd_out_if result_ch ();

    rv32i_instruction_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .instr   (instr_ch),
        .decoded (result_ch)
    );

    logic [31:0] instr_backlog [$];
    decode_t     expected_decodes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken;
    int hold_left;
    int stall_cycles;
    int requests_taken;
    int results_seen;
    int illegal_seen;
    int mismatches;

    always #10 clk = ~clk;

    // Predicted decode of one instruction word
    function automatic decode_t decode_rv32i(input logic [31:0] w);
        decode_t r;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
        f3 = w[14:12];
        f7 = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_u = w & rvd_pkg::UPPER_MASK;
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r = '0;
        r.word = w;
        case (w[6:0])
            rvd_pkg::OPC_OP: begin
                r.rd = w[11:7]; r.rs1 = w[19:15]; r.rs2 = w[24:20];
                if (f7 == rvd_pkg::F7_BASE) begin
                    case (f3)
                        3'd0: r.op = rvd_pkg::OP_ADD;
                        3'd1: r.op = rvd_pkg::OP_SLL;
                        3'd2: r.op = rvd_pkg::OP_SLT;
                        3'd3: r.op = rvd_pkg::OP_SLTU;
                        3'd4: r.op = rvd_pkg::OP_XOR;
                        3'd5: r.op = rvd_pkg::OP_SRL;
                        3'd6: r.op = rvd_pkg::OP_OR;
                        default: r.op = rvd_pkg::OP_AND;
                    endcase
                end
                else if (f7 == rvd_pkg::F7_ALT && f3 == 3'd0)
                    r.op = rvd_pkg::OP_SUB;
                else if (f7 == rvd_pkg::F7_ALT && f3 == 3'd5)
                    r.op = rvd_pkg::OP_SRA;
            end
            rvd_pkg::OPC_OPIMM: begin
                r.rd = w[11:7]; r.rs1 = w[19:15]; r.imm = imm_i; r.fmt = rvd_pkg::FMT_I;
                case (f3)
                    3'd0: r.op = rvd_pkg::OP_ADDI;
                    3'd2: r.op = rvd_pkg::OP_SLTI;
                    3'd3: r.op = rvd_pkg::OP_SLTIU;
                    3'd4: r.op = rvd_pkg::OP_XORI;
                    3'd6: r.op = rvd_pkg::OP_ORI;
                    3'd7: r.op = rvd_pkg::OP_ANDI;
                    default:
                    begin
                        // shifts carry the 5-bit amount; funct7 picks logical or arithmetic
                        r.imm = {27'd0, w[24:20]};
                        if (f7 == rvd_pkg::F7_BASE)
                            r.op = (f3 == 3'd1) ? rvd_pkg::OP_SLLI : rvd_pkg::OP_SRLI;
                        else if (f7 == rvd_pkg::F7_ALT && f3 == 3'd5)
                            r.op = rvd_pkg::OP_SRAI;
                    end
                endcase
            end
            rvd_pkg::OPC_LOAD: begin
                r.rd = w[11:7]; r.rs1 = w[19:15]; r.imm = imm_i; r.fmt = rvd_pkg::FMT_I;
                case (f3)
                    3'd0: r.op = rvd_pkg::OP_LB;
                    3'd1: r.op = rvd_pkg::OP_LH;
                    3'd2: r.op = rvd_pkg::OP_LW;
                    3'd4: r.op = rvd_pkg::OP_LBU;
                    3'd5: r.op = rvd_pkg::OP_LHU;
                    default: r.op = rvd_pkg::OP_ILLEGAL;
                endcase
            end
            rvd_pkg::OPC_STORE: begin
                r.rs1 = w[19:15]; r.rs2 = w[24:20]; r.imm = imm_s; r.fmt = rvd_pkg::FMT_S;
                case (f3)
                    3'd0: r.op = rvd_pkg::OP_SB;
                    3'd1: r.op = rvd_pkg::OP_SH;
                    3'd2: r.op = rvd_pkg::OP_SW;
                    default: r.op = rvd_pkg::OP_ILLEGAL;
                endcase
            end
            rvd_pkg::OPC_BRANCH: begin
                r.rs1 = w[19:15]; r.rs2 = w[24:20]; r.imm = imm_b; r.fmt = rvd_pkg::FMT_B;
                case (f3)
                    3'd0: r.op = rvd_pkg::OP_BEQ;
                    3'd1: r.op = rvd_pkg::OP_BNE;
                    3'd4: r.op = rvd_pkg::OP_BLT;
                    3'd5: r.op = rvd_pkg::OP_BGE;
                    3'd6: r.op = rvd_pkg::OP_BLTU;
                    3'd7: r.op = rvd_pkg::OP_BGEU;
                    default: r.op = rvd_pkg::OP_ILLEGAL;
                endcase
            end
            rvd_pkg::OPC_JAL: begin
                r.op = rvd_pkg::OP_JAL; r.rd = w[11:7]; r.imm = imm_j;
                r.fmt = rvd_pkg::FMT_J;
            end
            rvd_pkg::OPC_JALR: begin
                r.rd = w[11:7]; r.rs1 = w[19:15]; r.imm = imm_i; r.fmt = rvd_pkg::FMT_I;
                if (f3 == 3'd0)
                    r.op = rvd_pkg::OP_JALR;
            end
            rvd_pkg::OPC_LUI: begin
                r.op = rvd_pkg::OP_LUI; r.rd = w[11:7]; r.imm = imm_u;
                r.fmt = rvd_pkg::FMT_U;
            end
            rvd_pkg::OPC_AUIPC: begin
                r.op = rvd_pkg::OP_AUIPC; r.rd = w[11:7]; r.imm = imm_u;
                r.fmt = rvd_pkg::FMT_U;
            end
            // rd and rs1 bits are don't-care for the environment calls
            rvd_pkg::OPC_SYSTEM: begin
                if (f3 == 3'd0 && w[31:20] == 12'h000)
                    r.op = rvd_pkg::OP_ECALL;
                else if (f3 == 3'd0 && w[31:20] == 12'h001)
                    r.op = rvd_pkg::OP_EBREAK;
            end
            rvd_pkg::OPC_FENCE: begin
                if (f3 == 3'd0)
                    r.op = rvd_pkg::OP_FENCE;
                else if (f3 == 3'd1)
                    r.op = rvd_pkg::OP_FENCE_I;
            end
            default: r.op = rvd_pkg::OP_ILLEGAL;
        endcase
        // illegal encodings clear everything but the raw word
        if (r.op == rvd_pkg::OP_ILLEGAL)
        begin
            r = '0;
            r.word = w;
        end
        return r;
    endfunction

    // Mostly well-formed instructions with random fields, some raw noise
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        logic [6:0] f7;
        w = $urandom();
        if ($urandom_range(0, 99) < 10)
            return w;
        case ($urandom_range(0, 4))
            0, 1:    f7 = rvd_pkg::F7_BASE;
            2, 3:    f7 = rvd_pkg::F7_ALT;
            default: f7 = w[31:25];
        endcase
        case ($urandom_range(0, 10))
            0:  w[6:0] = rvd_pkg::OPC_OP;
            1:  w[6:0] = rvd_pkg::OPC_OPIMM;
            2:  w[6:0] = rvd_pkg::OPC_LOAD;
            3:  w[6:0] = rvd_pkg::OPC_STORE;
            4:  w[6:0] = rvd_pkg::OPC_BRANCH;
            5:  w[6:0] = rvd_pkg::OPC_JAL;
            6:  w[6:0] = rvd_pkg::OPC_JALR;
            7:  w[6:0] = rvd_pkg::OPC_LUI;
            8:  w[6:0] = rvd_pkg::OPC_AUIPC;
            9:  w[6:0] = rvd_pkg::OPC_SYSTEM;
            default: w[6:0] = rvd_pkg::OPC_FENCE;
        endcase
        if (w[6:0] == rvd_pkg::OPC_OP ||
            (w[6:0] == rvd_pkg::OPC_OPIMM && w[13:12] == 2'b01))
            w[31:25] = f7;
        if ((w[6:0] == rvd_pkg::OPC_SYSTEM || w[6:0] == rvd_pkg::OPC_JALR) &&
            $urandom_range(0, 3) != 0)
            w[14:12] = 3'd0;
        if (w[6:0] == rvd_pkg::OPC_SYSTEM && $urandom_range(0, 3) != 0)
            w[31:20] = 12'($urandom_range(0, 1));
        return w;
    endfunction

    // Request driver: holds a word until taken, then pulls the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            instr_ch.valid            <= 1'b0;
            instr_ch.instruction_word <= '0;
        end
        else
        begin
            if (instr_ch.valid && instr_ch.ready)
            begin
                expected_decodes.push_back(decode_rv32i(instr_ch.instruction_word));
                requests_taken++;
            end
            if (!instr_ch.valid || instr_ch.ready)
            begin
                if (instr_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    instr_ch.valid            <= 1'b1;
                    instr_ch.instruction_word <= instr_backlog.pop_front();
                end
                else
                    instr_ch.valid <= 1'b0;
            end
        end
    end

    // Result-side ready: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_taken      <= 1'b0;
            hold_left       <= 0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken      <= 1'b1;
            hold_left       <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        decode_t got;
        decode_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.op_code, result_ch.dest_reg, result_ch.src_reg_a,
                    result_ch.src_reg_b, result_ch.immediate, result_ch.imm_format,
                    result_ch.raw_word};
            results_seen++;
            if (got.op == rvd_pkg::OP_ILLEGAL)
                illegal_seen++;
            if (expected_decodes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result for word %h, nothing pending", got.word);
            end
            else
            begin
                want = expected_decodes.pop_front();
                if (got.op !== want.op || got.rd !== want.rd || got.rs1 !== want.rs1 ||
                    got.rs2 !== want.rs2 || got.imm !== want.imm ||
                    got.fmt !== want.fmt || got.word !== want.word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch %h: exp op %0d rd %0d rs1 %0d rs2 %0d imm %h fmt %0d",
                                 want.word, want.op, want.rd, want.rs1, want.rs2,
                                 want.imm, want.fmt);
                        $display("     got %h:     op %0d rd %0d rs1 %0d rs2 %0d imm %h fmt %0d",
                                 got.word, got.op, got.rd, got.rs1, got.rs2,
                                 got.imm, got.fmt);
                    end
                end
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if (!rst_n || (instr_ch.valid && instr_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Stimulus sequencing
    initial
    begin
        rst_n = 1'b0;
        instr_ch.valid = 1'b0;
        instr_ch.instruction_word = '0;
        result_ch.ready = 1'b0;
        stall_cycles = 0;
        requests_taken = 0;
        results_seen = 0;
        illegal_seen = 0;
        mismatches = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, each class, each illegal case
        instr_backlog = '{
            32'h0000_0000,
            32'hFFFF_FFFF,
            {rvd_pkg::F7_BASE, 5'd31, 5'd31, 3'd0, 5'd31, rvd_pkg::OPC_OP},
            {rvd_pkg::F7_ALT, 5'd1, 5'd2, 3'd0, 5'd3, rvd_pkg::OPC_OP},
            {rvd_pkg::F7_ALT, 5'd31, 5'd0, 3'd5, 5'd1, rvd_pkg::OPC_OP},
            {rvd_pkg::F7_ALT, 5'd4, 5'd5, 3'd1, 5'd6, rvd_pkg::OPC_OP},
            {7'h01, 5'd4, 5'd5, 3'd0, 5'd6, rvd_pkg::OPC_OP},
            {12'h800, 5'd31, 3'd0, 5'd31, rvd_pkg::OPC_OPIMM},
            {12'h7FF, 5'd1, 3'd7, 5'd2, rvd_pkg::OPC_OPIMM},
            {rvd_pkg::F7_BASE, 5'd31, 5'd5, 3'd1, 5'd6, rvd_pkg::OPC_OPIMM},
            {rvd_pkg::F7_ALT, 5'd31, 5'd5, 3'd5, 5'd6, rvd_pkg::OPC_OPIMM},
            {rvd_pkg::F7_ALT, 5'd3, 5'd5, 3'd1, 5'd6, rvd_pkg::OPC_OPIMM},
            {7'h01, 5'd3, 5'd5, 3'd5, 5'd6, rvd_pkg::OPC_OPIMM},
            {12'h800, 5'd1, 3'd2, 5'd2, rvd_pkg::OPC_LOAD},
            {12'hFFF, 5'd1, 3'd3, 5'd2, rvd_pkg::OPC_LOAD},
            {7'h7F, 5'd31, 5'd31, 3'd2, 5'd31, rvd_pkg::OPC_STORE},
            {7'h3F, 5'd1, 5'd2, 3'd3, 5'd31, rvd_pkg::OPC_STORE},
            {1'b1, 6'h00, 5'd1, 5'd2, 3'd0, 4'h0, 1'b0, rvd_pkg::OPC_BRANCH},
            {1'b0, 6'h3F, 5'd3, 5'd4, 3'd7, 4'hF, 1'b1, rvd_pkg::OPC_BRANCH},
            {7'h00, 5'd1, 5'd2, 3'd2, 5'd0, rvd_pkg::OPC_BRANCH},
            {20'h80000, 5'd1, rvd_pkg::OPC_JAL},
            {20'h7FFFF, 5'd31, rvd_pkg::OPC_JAL},
            {12'hFFF, 5'd7, 3'd0, 5'd8, rvd_pkg::OPC_JALR},
            {12'h000, 5'd7, 3'd1, 5'd8, rvd_pkg::OPC_JALR},
            {20'hFFFFF, 5'd31, rvd_pkg::OPC_LUI},
            {20'h00001, 5'd0, rvd_pkg::OPC_AUIPC},
            {12'h000, 5'd31, 3'd0, 5'd31, rvd_pkg::OPC_SYSTEM},
            {12'h001, 5'd0, 3'd0, 5'd0, rvd_pkg::OPC_SYSTEM},
            {12'h002, 5'd0, 3'd0, 5'd0, rvd_pkg::OPC_SYSTEM},
            {12'h300, 5'd1, 3'd1, 5'd2, rvd_pkg::OPC_SYSTEM},
            {17'h1FFFF, 3'd0, 5'h1F, rvd_pkg::OPC_FENCE},
            {17'h1ABCD, 3'd1, 5'd9, rvd_pkg::OPC_FENCE},
            {17'h00000, 3'd2, 5'd0, rvd_pkg::OPC_FENCE}
        };
        while (instr_backlog.size() != 0 || instr_ch.valid || expected_decodes.size() != 0)
            @(negedge clk);

        // random phases with different flow-control mixes
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = SEND_IDLE[phase];
            recv_idle_pct = RECV_IDLE[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
                instr_backlog.push_back(random_instruction());
            // long output stall while requests keep coming, to back up the pipeline
            if (phase == 0)
                hold_req = 1'b1;
            while (instr_backlog.size() != 0 || instr_ch.valid ||
                   expected_decodes.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        if (expected_decodes.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_decodes.size());
            mismatches += expected_decodes.size();
        end

        $display("Decoded %0d requests into %0d results (%0d illegal), %0d errors;",
                 requests_taken, results_seen, illegal_seen, mismatches);
        $display("flow control: free-running, input gaps, output stalls, both, long hold-off.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
